### rtl/ccsg_pkg.sv
package ccsg_pkg;

    // Fixed field widths of the message and reply beats.
    localparam int CMD_W     = 4;
    localparam int SEQ_W     = 16;
    localparam int WORD_W    = 64;
    localparam int VER_W     = 16;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 3;

    // Depth of the queue between the front and the back end.
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    // Offset between the peer sequence number and our own after a hello.
    localparam logic [SEQ_W-1:0] SEQ_OFFSET = 16'd2909;

    // Command opcodes.
    localparam logic [CMD_W-1:0] OP_HELLO       = 4'd0;
    localparam logic [CMD_W-1:0] OP_CHALLENGE   = 4'd1;
    localparam logic [CMD_W-1:0] OP_RESPONSE    = 4'd2;
    localparam logic [CMD_W-1:0] OP_GETCFG      = 4'd3;
    localparam logic [CMD_W-1:0] OP_RECONF      = 4'd4;
    localparam logic [CMD_W-1:0] OP_START       = 4'd5;
    localparam logic [CMD_W-1:0] OP_STOP        = 4'd6;
    localparam logic [CMD_W-1:0] OP_DELAYRECONF = 4'd7;
    localparam logic [CMD_W-1:0] OP_PANIC       = 4'd10;
    localparam logic [CMD_W-1:0] OP_RESSTAT     = 4'd11;
    localparam logic [CMD_W-1:0] OP_CANCEL      = 4'd13;

    // Reply status codes.
    localparam logic [STATUS_W-1:0] RS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] RS_EAUTH      = 3'd1;
    localparam logic [STATUS_W-1:0] RS_BADSEQ     = 3'd2;
    localparam logic [STATUS_W-1:0] RS_NOTSUPP    = 3'd3;
    localparam logic [STATUS_W-1:0] RS_DISPATCHED = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_VERSION_MAJOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION_MINOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_KEY       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEER_KEY      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE         = 3'd4;

    // Session state.
    typedef enum logic [1:0] {
        LINK_UNCONN = 2'd0,
        LINK_CHAL   = 2'd1,
        LINK_CONN   = 2'd2
    } link_state_t;

    // A message after classification by the front end.
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [SEQ_W-1:0] seq_num;
        logic             is_hello;
        logic             is_response;
        logic             version_ok;
        logic             auth_ok;
        logic             executable;
    } cls_t;

    // Configuration values the back end needs to build replies.
    typedef struct packed {
        logic [VER_W-1:0]  version_major;
        logic [VER_W-1:0]  version_minor;
        logic [WORD_W-1:0] challenge_code;
    } cfg_view_t;

    // Queue occupancy seen by the front end and the top level.
    typedef struct packed {
        logic [QCOUNT_W-1:0] count;
        logic                full;
        logic                empty;
    } q_status_t;

    // Commands that a connected session hands to the executor.
    function automatic logic is_executable(input logic [CMD_W-1:0] cmd);
        logic result;
        case (cmd)
            OP_GETCFG, OP_RECONF, OP_START, OP_STOP, OP_DELAYRECONF,
            OP_PANIC, OP_RESSTAT, OP_CANCEL: result = 1'b1;
            default:                         result = 1'b0;
        endcase
        return result;
    endfunction

endpackage

### rtl/ccsg_msg_if.sv
interface ccsg_msg_if
    import ccsg_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [SEQ_W-1:0]  seq_num;
    logic [WORD_W-1:0] payload;

    modport source (output valid, output command, output seq_num, output payload,
                    input ready);
    modport sink (input valid, input command, input seq_num, input payload,
                  output ready);
endinterface

### rtl/ccsg_reply_if.sv
interface ccsg_reply_if
    import ccsg_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    reply_command;
    logic [STATUS_W-1:0] reply_status;
    logic [SEQ_W-1:0]    reply_seq;
    logic [WORD_W-1:0]   reply_word0;
    logic [VER_W-1:0]    reply_word1;
    logic                dispatch;

    modport source (output valid, output reply_command, output reply_status,
                    output reply_seq, output reply_word0, output reply_word1,
                    output dispatch, input ready);
    modport sink (input valid, input reply_command, input reply_status,
                  input reply_seq, input reply_word0, input reply_word1,
                  input dispatch, output ready);
endinterface

### rtl/ccsg_cfg_if.sv
interface ccsg_cfg_if
    import ccsg_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/ccsg_front.sv
module ccsg_front
    import ccsg_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    ccsg_msg_if.sink        msg,
    ccsg_cfg_if.sink        cfg,
    input  q_status_t       q_status,
    output logic            push,
    output cls_t            item,
    output cfg_view_t       cfg_view
);

    logic [VER_W-1:0]  version_major_reg;
    logic [VER_W-1:0]  version_minor_reg;
    logic [WORD_W-1:0] own_key_reg;
    logic [WORD_W-1:0] peer_key_reg;
    logic [WORD_W-1:0] nonce_reg;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_major_reg <= 16'd1;
            version_minor_reg <= '0;
            own_key_reg       <= '0;
            peer_key_reg      <= '0;
            nonce_reg         <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_VERSION_MAJOR: version_major_reg <= cfg.data[VER_W-1:0];
                REG_VERSION_MINOR: version_minor_reg <= cfg.data[VER_W-1:0];
                REG_OWN_KEY:       own_key_reg       <= cfg.data;
                REG_PEER_KEY:      peer_key_reg      <= cfg.data;
                REG_NONCE:         nonce_reg         <= cfg.data;
                default:           ;
            endcase
        end
    end

    // A message beat is taken whenever the queue has room.
    assign msg.ready = !q_status.full;
    assign push      = msg.valid && msg.ready;

    // Classify the message: all checks that do not depend on session state.
    always_comb
    begin
        item.command     = msg.command;
        item.seq_num     = msg.seq_num;
        item.is_hello    = (msg.command == OP_HELLO);
        item.is_response = (msg.command == OP_RESPONSE);
        item.version_ok  = (msg.payload == {{(WORD_W-VER_W){1'b0}}, version_major_reg});
        item.auth_ok     = ((msg.payload ^ peer_key_reg) == nonce_reg);
        item.executable  = is_executable(msg.command);
    end

    // Values the back end stamps into replies.
    assign cfg_view.version_major  = version_major_reg;
    assign cfg_view.version_minor  = version_minor_reg;
    assign cfg_view.challenge_code = own_key_reg ^ nonce_reg;

endmodule

### rtl/ccsg_queue.sv
module ccsg_queue
    import ccsg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cls_t      push_item,
    input  logic      pop,
    output logic      head_valid,
    output cls_t      head_item,
    output q_status_t status
);

    cls_t                entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCOUNT_W-1:0] count_reg;
    logic                do_pop;

    assign do_pop = pop && (count_reg != '0);

    // Pointers wrap at the queue depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_valid   = (count_reg != '0);
    assign head_item    = entry_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.full  = (count_reg == QCOUNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);

endmodule

### rtl/ccsg_back.sv
module ccsg_back
    import ccsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  cls_t        head_item,
    input  cfg_view_t   cfg_view,
    output logic        pop,
    ccsg_reply_if.source reply
);

    link_state_t         link_state_reg;
    link_state_t         link_state_next;
    logic [SEQ_W-1:0]    exp_seq_reg;
    logic [SEQ_W-1:0]    exp_seq_next;
    logic [SEQ_W-1:0]    own_seq_reg;
    logic [SEQ_W-1:0]    own_seq_next;
    logic [SEQ_W-1:0]    stamp_seq;
    logic [SEQ_W-1:0]    hello_exp_seq;
    logic                seq_match;

    logic                out_valid_reg;
    logic [CMD_W-1:0]    out_cmd_reg;
    logic [CMD_W-1:0]    out_cmd_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [STATUS_W-1:0] out_status_next;
    logic [SEQ_W-1:0]    out_seq_reg;
    logic [WORD_W-1:0]   out_word0_reg;
    logic [WORD_W-1:0]   out_word0_next;
    logic [VER_W-1:0]    out_word1_reg;
    logic [VER_W-1:0]    out_word1_next;
    logic                out_disp_reg;
    logic                out_disp_next;

    // The head beat is executed when the reply register is free or draining.
    assign pop = head_valid && (!out_valid_reg || reply.ready);

    assign hello_exp_seq = head_item.seq_num + 16'd1;
    assign seq_match     = (head_item.seq_num == exp_seq_reg);
    assign stamp_seq     = head_item.is_hello ? hello_exp_seq + SEQ_OFFSET : own_seq_reg;
    assign own_seq_next  = stamp_seq + 16'd1;

    // Next session state and expected peer sequence number.
    always_comb
    begin
        link_state_next = link_state_reg;
        exp_seq_next    = exp_seq_reg;
        if (head_item.is_hello)
        begin
            exp_seq_next    = hello_exp_seq;
            link_state_next = head_item.version_ok ? LINK_CHAL : LINK_UNCONN;
        end
        else
        begin
            case (link_state_reg)
                LINK_UNCONN:
                begin
                    link_state_next = LINK_UNCONN;
                end
                LINK_CHAL:
                begin
                    if (!seq_match)
                    begin
                        link_state_next = LINK_UNCONN;
                    end
                    else
                    begin
                        exp_seq_next    = exp_seq_reg + 16'd1;
                        link_state_next = (head_item.is_response && head_item.auth_ok) ?
                                          LINK_CONN : LINK_UNCONN;
                    end
                end
                LINK_CONN:
                begin
                    if (!seq_match)
                    begin
                        link_state_next = LINK_UNCONN;
                    end
                    else
                    begin
                        exp_seq_next    = exp_seq_reg + 16'd1;
                        link_state_next = head_item.executable ? LINK_CONN : LINK_UNCONN;
                    end
                end
                default:
                begin
                    link_state_next = LINK_UNCONN;
                end
            endcase
        end
    end

    // Reply contents for the head beat.
    always_comb
    begin
        out_cmd_next    = head_item.command;
        out_status_next = RS_EAUTH;
        out_word0_next  = '0;
        out_word1_next  = '0;
        out_disp_next   = 1'b0;
        if (head_item.is_hello)
        begin
            if (head_item.version_ok)
            begin
                out_cmd_next    = OP_CHALLENGE;
                out_status_next = RS_OK;
                out_word0_next  = cfg_view.challenge_code;
            end
            else
            begin
                out_cmd_next    = OP_HELLO;
                out_status_next = RS_NOTSUPP;
                out_word0_next  = {{(WORD_W-VER_W){1'b0}}, cfg_view.version_major};
                out_word1_next  = cfg_view.version_minor;
            end
        end
        else
        begin
            case (link_state_reg)
                LINK_CHAL:
                begin
                    if (!seq_match)
                    begin
                        out_status_next = RS_BADSEQ;
                    end
                    else if (head_item.is_response && head_item.auth_ok)
                    begin
                        out_status_next = RS_OK;
                    end
                end
                LINK_CONN:
                begin
                    if (!seq_match)
                    begin
                        out_status_next = RS_BADSEQ;
                    end
                    else if (head_item.executable)
                    begin
                        out_status_next = RS_DISPATCHED;
                        out_disp_next   = 1'b1;
                    end
                end
                default:
                begin
                    out_status_next = RS_EAUTH;
                end
            endcase
        end
    end

    // Session state and reply valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_state_reg <= LINK_UNCONN;
            exp_seq_reg    <= '0;
            own_seq_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                link_state_reg <= link_state_next;
                exp_seq_reg    <= exp_seq_next;
                own_seq_reg    <= own_seq_next;
                out_valid_reg  <= 1'b1;
            end
            else if (reply.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Reply payload register.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_cmd_reg    <= out_cmd_next;
            out_status_reg <= out_status_next;
            out_seq_reg    <= stamp_seq;
            out_word0_reg  <= out_word0_next;
            out_word1_reg  <= out_word1_next;
            out_disp_reg   <= out_disp_next;
        end
    end

    assign reply.valid         = out_valid_reg;
    assign reply.reply_command = out_cmd_reg;
    assign reply.reply_status  = out_status_reg;
    assign reply.reply_seq     = out_seq_reg;
    assign reply.reply_word0   = out_word0_reg;
    assign reply.reply_word1   = out_word1_reg;
    assign reply.dispatch      = out_disp_reg;

endmodule

### rtl/control_channel_session_gate.sv
// Control channel session gate.
// Channels: msg carries control message beats (command, seq_num, payload),
// reply carries one reply beat per message, and cfg writes the five
// configuration registers by index (version major/minor, own and peer
// challenge keys, nonce). All channels use valid/ready; cfg is always ready.
// Every accepted message beat produces exactly one reply beat, in order.
// Path: an accepted beat goes into the two-entry queue and, once the reply
// register is free or draining, into the reply register that drives reply.
// Throughput: one message per cycle while reply.ready stays high; the queue
// lets the front keep taking beats while the back end waits on a stalled
// reply.
// When the receiver holds reply.ready low, the reply register holds its beat,
// the queue fills and msg.ready drops once the queue holds two beats.
// Reset clears the session to unconnected, both sequence numbers to zero,
// version_major to one and all other configuration registers to zero.
// The user must write configuration only while no message is in flight; the block itself does not enforce it.
module control_channel_session_gate
    import ccsg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ccsg_msg_if.sink     msg,
    ccsg_reply_if.source reply,
    ccsg_cfg_if.sink     cfg
);

    logic      push;
    logic      pop;
    logic      head_valid;
    cls_t      push_item;
    cls_t      head_item;
    cfg_view_t cfg_view;
    q_status_t q_status;

    // Accept and classify messages, hold configuration.
    ccsg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .msg      (msg),
        .cfg      (cfg),
        .q_status (q_status),
        .push     (push),
        .item     (push_item),
        .cfg_view (cfg_view)
    );

    // Decouple classification from execution.
    ccsg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .status     (q_status)
    );

    // Run the session and build replies.
    ccsg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .cfg_view   (cfg_view),
        .pop        (pop),
        .reply      (reply)
    );

    // The queue never holds more beats than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= QCOUNT_W'(QDEPTH))
        else $error("queue count exceeds depth");

    // A beat taken without a pop leaves the queue non-empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !q_status.empty)
        else $error("pushed beat lost from queue");

    // A pop only happens when a beat is present, and then a reply follows.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> reply.valid)
        else $error("executed beat produced no reply");

    // Dispatch is flagged only with the dispatched status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (reply.valid && reply.dispatch) |-> (reply.reply_status == RS_DISPATCHED))
        else $error("dispatch without dispatched status");

endmodule

### tb/sv/tb_control_channel_session_gate.sv
`timescale 1ns / 1ps

// One reply beat as the session gate produces it.
typedef struct packed {
    logic [ccsg_pkg::CMD_W-1:0]    command;
    logic [ccsg_pkg::STATUS_W-1:0] status;
    logic [ccsg_pkg::SEQ_W-1:0]    seq;
    logic [ccsg_pkg::WORD_W-1:0]   word0;
    logic [ccsg_pkg::VER_W-1:0]    word1;
    logic                          dispatch;
} reply_beat_t;

// Session model of the gate: keeps its own copy of the registers and the
// session, predicts one reply per accepted message and checks replies in order.
class session_scoreboard;
    logic [ccsg_pkg::VER_W-1:0]  version_major;
    logic [ccsg_pkg::VER_W-1:0]  version_minor;
    logic [ccsg_pkg::WORD_W-1:0] own_key;
    logic [ccsg_pkg::WORD_W-1:0] peer_key;
    logic [ccsg_pkg::WORD_W-1:0] nonce;

    ccsg_pkg::link_state_t       link;
    logic [ccsg_pkg::SEQ_W-1:0]  peer_seq_due;
    logic [ccsg_pkg::SEQ_W-1:0]  own_seq;

    reply_beat_t                 replies_due[$];
    int                          mismatches;

    function new();
        version_major = 16'd1;
        version_minor = '0;
        own_key       = '0;
        peer_key      = '0;
        nonce         = '0;
        link          = ccsg_pkg::LINK_UNCONN;
        peer_seq_due  = '0;
        own_seq       = '0;
        mismatches    = 0;
    endfunction

    // Commands that a connected session hands on to the executor.
    static function bit dispatchable(input logic [ccsg_pkg::CMD_W-1:0] cmd);
        bit hit;
        case (cmd)
            ccsg_pkg::OP_GETCFG, ccsg_pkg::OP_RECONF, ccsg_pkg::OP_START,
            ccsg_pkg::OP_STOP, ccsg_pkg::OP_DELAYRECONF, ccsg_pkg::OP_PANIC,
            ccsg_pkg::OP_RESSTAT, ccsg_pkg::OP_CANCEL: hit = 1'b1;
            default:                                  hit = 1'b0;
        endcase
        return hit;
    endfunction

    function void write_reg(input logic [ccsg_pkg::CFG_IDX_W-1:0] idx,
                            input logic [ccsg_pkg::WORD_W-1:0] data);
        case (idx)
            ccsg_pkg::REG_VERSION_MAJOR: version_major = data[ccsg_pkg::VER_W-1:0];
            ccsg_pkg::REG_VERSION_MINOR: version_minor = data[ccsg_pkg::VER_W-1:0];
            ccsg_pkg::REG_OWN_KEY:       own_key = data;
            ccsg_pkg::REG_PEER_KEY:      peer_key = data;
            ccsg_pkg::REG_NONCE:         nonce = data;
            default:                     ;
        endcase
    endfunction

    function int pending_count();
        return replies_due.size();
    endfunction

    // Works out the reply to one accepted message and advances the session.
    function void note_message(input logic [ccsg_pkg::CMD_W-1:0] cmd,
                               input logic [ccsg_pkg::SEQ_W-1:0] seq,
                               input logic [ccsg_pkg::WORD_W-1:0] payload);
        reply_beat_t r;
        r = '0;
        r.command = cmd;
        if (cmd == ccsg_pkg::OP_HELLO)
        begin
            // A hello restarts both sequence numbers in any state.
            peer_seq_due = seq + 16'd1;
            own_seq      = peer_seq_due + ccsg_pkg::SEQ_OFFSET;
            if (payload != {48'd0, version_major})
            begin
                link      = ccsg_pkg::LINK_UNCONN;
                r.command = ccsg_pkg::OP_HELLO;
                r.status  = ccsg_pkg::RS_NOTSUPP;
                r.word0   = {48'd0, version_major};
                r.word1   = version_minor;
            end
            else
            begin
                link      = ccsg_pkg::LINK_CHAL;
                r.command = ccsg_pkg::OP_CHALLENGE;
                r.status  = ccsg_pkg::RS_OK;
                r.word0   = own_key ^ nonce;
            end
        end
        else if (link == ccsg_pkg::LINK_UNCONN)
        begin
            r.status = ccsg_pkg::RS_EAUTH;
        end
        else if (seq != peer_seq_due)
        begin
            link     = ccsg_pkg::LINK_UNCONN;
            r.status = ccsg_pkg::RS_BADSEQ;
        end
        else
        begin
            peer_seq_due = peer_seq_due + 16'd1;
            if (link == ccsg_pkg::LINK_CHAL)
            begin
                if (cmd != ccsg_pkg::OP_RESPONSE || (payload ^ peer_key) != nonce)
                begin
                    link     = ccsg_pkg::LINK_UNCONN;
                    r.status = ccsg_pkg::RS_EAUTH;
                end
                else
                begin
                    link     = ccsg_pkg::LINK_CONN;
                    r.status = ccsg_pkg::RS_OK;
                end
            end
            else if (dispatchable(cmd))
            begin
                r.status   = ccsg_pkg::RS_DISPATCHED;
                r.dispatch = 1'b1;
            end
            else
            begin
                link     = ccsg_pkg::LINK_UNCONN;
                r.status = ccsg_pkg::RS_EAUTH;
            end
        end
        r.seq   = own_seq;
        own_seq = own_seq + 16'd1;
        replies_due.push_back(r);
    endfunction

    // Compares one accepted reply beat with the oldest prediction.
    function void check_reply(input reply_beat_t act);
        reply_beat_t exp;
        if (replies_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected reply beat: cmd %h status %h seq %h w0 %h w1 %h disp %b",
                         act.command, act.status, act.seq, act.word0, act.word1,
                         act.dispatch);
            return;
        end
        exp = replies_due.pop_front();
        if (act.command !== exp.command || act.status !== exp.status ||
            act.seq !== exp.seq || act.word0 !== exp.word0 ||
            act.word1 !== exp.word1 || act.dispatch !== exp.dispatch)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("reply mismatch, expected: cmd %h status %h seq %h w0 %h w1 %h disp %b",
                         exp.command, exp.status, exp.seq, exp.word0, exp.word1,
                         exp.dispatch);
                $display("                 actual: cmd %h status %h seq %h w0 %h w1 %h disp %b",
                         act.command, act.status, act.seq, act.word0, act.word1,
                         act.dispatch);
            end
        end
    endfunction
endclass

module tb_control_channel_session_gate
    import ccsg_pkg::*;
();
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;
    localparam int TAIL_CYCLES    = 4;

    // Opcodes the package leaves unnamed.
    localparam logic [CMD_W-1:0] OP_SUSPEND = 4'd8;
    localparam logic [CMD_W-1:0] OP_OTHER   = 4'd15;

    localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

    logic clk;
    logic rst_n;

    ccsg_msg_if   msg_if();
    ccsg_reply_if reply_if();
    ccsg_cfg_if   cfg_if();

    control_channel_session_gate u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if.sink),
        .reply (reply_if.source),
        .cfg   (cfg_if.sink)
    );

    session_scoreboard sb = new();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_reply    = 1'b0;
    bit start_hold    = 1'b0;
    int idle_cycles;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: random stalls, plus one long hold-off when asked for.
    initial
    begin
        reply_if.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            reply_if.ready <= !hold_reply && ($urandom_range(99) >= stall_pct);
        end
    end

    // Long hold-off of the reply channel, counted here in cycles.
    initial
    begin
        wait (start_hold);
        @(posedge clk);
        hold_reply = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_reply = 1'b0;
    end

    // Monitors: note each accepted message beat and check each reply beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (msg_if.valid && msg_if.ready)
                sb.note_message(msg_if.command, msg_if.seq_num, msg_if.payload);
            if (reply_if.valid && reply_if.ready)
                sb.check_reply('{reply_if.reply_command, reply_if.reply_status,
                                 reply_if.reply_seq, reply_if.reply_word0,
                                 reply_if.reply_word1, reply_if.dispatch});
        end
    end

    // Watchdog: ends the run when no beat moves on any channel for too long.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((msg_if.valid && msg_if.ready) || (reply_if.valid && reply_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Offers one message beat; entered and left at a falling edge.
    task automatic send_message(input logic [CMD_W-1:0] cmd, input logic [SEQ_W-1:0] seq,
                                input logic [WORD_W-1:0] payload);
        while ($urandom_range(99) < send_idle_pct)
        begin
            msg_if.valid <= 1'b0;
            @(negedge clk);
        end
        msg_if.valid   <= 1'b1;
        msg_if.command <= cmd;
        msg_if.seq_num <= seq;
        msg_if.payload <= payload;
        do @(posedge clk); while (!msg_if.ready);
        @(negedge clk);
    endtask

    // Writes one register; the caller lowers valid after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    // Waits until every predicted reply has arrived, plus the pipeline tail.
    task automatic drain_replies();
        while (sb.pending_count() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Ends the current phase and loads a full register setting.
    task automatic configure(input logic [VER_W-1:0] major, input logic [VER_W-1:0] minor,
                             input logic [WORD_W-1:0] own_key,
                             input logic [WORD_W-1:0] peer_key,
                             input logic [WORD_W-1:0] nonce);
        msg_if.valid <= 1'b0;
        drain_replies();
        write_reg(REG_VERSION_MAJOR, {48'd0, major});
        write_reg(REG_VERSION_MINOR, {48'd0, minor});
        write_reg(REG_OWN_KEY, own_key);
        write_reg(REG_PEER_KEY, peer_key);
        write_reg(REG_NONCE, nonce);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input bit want_dispatch);
        logic [CMD_W-1:0] cmd;
        do cmd = CMD_W'($urandom_range(1, 15));
        while (is_executable(cmd) != want_dispatch);
        return cmd;
    endfunction

    // Random traffic: mostly complete sessions with random content, the rest
    // broken sessions and noise.
    task automatic run_traffic(input int n_items);
        int               sent;
        int               pick;
        int               n_cmds;
        bit               alive;
        logic [SEQ_W-1:0] seq;
        logic [WORD_W-1:0] payload;
        logic [CMD_W-1:0] cmd;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 10)
            begin
                send_message(CMD_W'($urandom_range(15)), SEQ_W'($urandom_range(65535)),
                             random_word());
                sent++;
            end
            else
            begin
                // Hello: usually the right version, sometimes with stray upper bits.
                seq  = SEQ_W'($urandom_range(65535));
                pick = $urandom_range(99);
                if (pick < 85)
                    payload = {48'd0, sb.version_major};
                else if (pick < 92)
                    payload = {48'd0, sb.version_major} ^
                              (64'd1 << $urandom_range(63, VER_W));
                else
                    payload = random_word();
                send_message(OP_HELLO, seq, payload);
                sent++;
                alive = (payload == {48'd0, sb.version_major});
                seq   = seq + 16'd1;

                // Response to the challenge: good, bad key, bad sequence or wrong opcode.
                if (alive)
                begin
                    pick    = $urandom_range(99);
                    cmd     = OP_RESPONSE;
                    payload = sb.nonce ^ sb.peer_key;
                    if (pick >= 80 && pick < 87)
                        payload = payload ^ (64'd1 << $urandom_range(63));
                    else if (pick >= 87 && pick < 94)
                        seq = seq + 16'($urandom_range(1, 65535));
                    else if (pick >= 94)
                    begin
                        cmd = CMD_W'($urandom_range(1, 15));
                        if (cmd == OP_RESPONSE)
                            cmd = OP_CHALLENGE;
                    end
                    send_message(cmd, seq, payload);
                    sent++;
                    alive = (pick < 80);
                    seq   = seq + 16'd1;
                end

                // Connected traffic until the session ends or is broken.
                if (alive)
                begin
                    n_cmds = $urandom_range(12);
                    for (int i = 0; i < n_cmds && alive; i++)
                    begin
                        pick = $urandom_range(99);
                        if (pick < 88)
                        begin
                            send_message(pick_command(1'b1), seq, random_word());
                            seq = seq + 16'd1;
                        end
                        else if (pick < 94)
                        begin
                            send_message(pick_command(1'b0), seq, random_word());
                            alive = 1'b0;
                        end
                        else
                        begin
                            send_message(pick_command(1'b1), seq + 16'($urandom_range(1, 65535)),
                                         random_word());
                            alive = 1'b0;
                        end
                        sent++;
                    end
                end
            end
        end
    endtask

    // Stimulus.
    initial
    begin
        logic [SEQ_W-1:0] seq;
        rst_n          = 1'b0;
        msg_if.valid   <= 1'b0;
        msg_if.command <= '0;
        msg_if.seq_num <= '0;
        msg_if.payload <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= '0;
        cfg_if.data    <= '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed part under the reset register values.
        // Anything but a hello is refused while unconnected.
        send_message(OP_RESPONSE, 16'h1234, 64'h0);
        send_message(OP_OTHER, 16'hFFFF, ALL_ONES);
        // Hello with a wrong version, then one that differs only in the upper bits.
        send_message(OP_HELLO, 16'hFFFF, 64'h0);
        send_message(OP_HELLO, 16'h0001, 64'h8000_0000_0000_0001);
        // Accepted hello with the peer sequence wrapping, then a non-response.
        send_message(OP_HELLO, 16'hFFFF, 64'h1);
        send_message(OP_GETCFG, 16'h0000, 64'h0);
        // Response with a bad key.
        send_message(OP_HELLO, 16'd100, 64'h1);
        send_message(OP_RESPONSE, 16'd101, 64'h1);
        // Response with a bad sequence number.
        send_message(OP_HELLO, 16'd200, 64'h1);
        send_message(OP_RESPONSE, 16'd202, 64'h0);
        // Session whose own sequence number wraps, then every executable command.
        send_message(OP_HELLO, 16'hF4A1, 64'h1);
        send_message(OP_RESPONSE, 16'hF4A2, 64'h0);
        seq = 16'hF4A3;
        for (int c = 0; c < 16; c++)
        begin
            if (is_executable(CMD_W'(c)))
            begin
                send_message(CMD_W'(c), seq, random_word());
                seq = seq + 16'd1;
            end
        end
        // Sequence mismatch while connected.
        send_message(OP_GETCFG, 16'h0000, ALL_ONES);
        // Suspend drops a connected session.
        send_message(OP_HELLO, 16'd400, 64'h1);
        send_message(OP_RESPONSE, 16'd401, 64'h0);
        send_message(OP_SUSPEND, 16'd402, 64'h0);

        // All registers at zero, no idling, with the long reply hold-off.
        configure(16'h0000, 16'h0000, 64'h0, 64'h0, 64'h0);
        send_idle_pct = 0;
        stall_pct     = 0;
        run_traffic(80);
        start_hold = 1'b1;
        run_traffic(220);

        // All registers at all ones, sender mostly idle.
        configure(16'hFFFF, 16'hFFFF, ALL_ONES, ALL_ONES, ALL_ONES);
        send_idle_pct = 80;
        stall_pct     = 0;
        run_traffic(300);

        // Random registers, receiver mostly stalled.
        configure(VER_W'($urandom_range(65535)), VER_W'($urandom_range(65535)), random_word(),
                  random_word(), random_word());
        send_idle_pct = 0;
        stall_pct     = 80;
        run_traffic(300);

        // Random registers, light idling on both sides.
        configure(VER_W'($urandom_range(65535)), VER_W'($urandom_range(65535)), random_word(),
                  random_word(), random_word());
        send_idle_pct = 13;
        stall_pct     = 13;
        run_traffic(300);

        // Mixed setting, no idling.
        configure(16'h0001, VER_W'($urandom_range(65535)), random_word(), ALL_ONES, 64'h0);
        send_idle_pct = 0;
        stall_pct     = 0;
        run_traffic(50);

        msg_if.valid <= 1'b0;
        drain_replies();
        if (sb.mismatches == 0 && sb.pending_count() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

### sim.f
rtl/ccsg_pkg.sv
rtl/ccsg_msg_if.sv
rtl/ccsg_reply_if.sv
rtl/ccsg_cfg_if.sv
rtl/ccsg_front.sv
rtl/ccsg_queue.sv
rtl/ccsg_back.sv
rtl/control_channel_session_gate.sv
tb/sv/tb_control_channel_session_gate.sv
